/* hdl/sktab_pkg.sv */
`default_nettype none
package sktab_pkg;

   localparam int CAPACITY_DEF  = 256;
   localparam int KEY_WIDTH_DEF = 31;
   // cells per first-level group of the readout tree
   localparam int GROUP         = 16;

   localparam int REQ_W = 72;    // 67 payload bits, padded to bytes
   localparam int RSP_W = 176;   // 172 payload bits, padded to bytes

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_FIND   = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_POP    = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_NEW     = 3'd0,
      ST_UPDATED = 3'd1,
      ST_HIT     = 3'd2,
      ST_MISS    = 3'd3,
      ST_EMPTY   = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   // what every cell does on the apply cycle
   typedef enum logic [1:0] {
      OP_NONE,
      OP_INSERT,
      OP_UPDATE,
      OP_REMOVE
   } cell_op_type;

   typedef struct packed {
      logic        cmp_en;  // latch compare flags against the broadcast key
      logic        pop;     // compare for pop: pick the head cell
      cell_op_type op;
   } cell_ctl_type;

endpackage
`default_nettype wire

/* hdl/sktab_cell.sv */
`default_nettype none
module sktab_cell #(
   parameter int INDEX     = 0,
   parameter int KEY_WIDTH = sktab_pkg::KEY_WIDTH_DEF,
   parameter int CW        = 9,
   localparam int EW       = KEY_WIDTH + 33
) (
   input  wire logic                   clock,
   input  wire sktab_pkg::cell_ctl_type ctl,
   input  wire logic [KEY_WIDTH-1:0]   key,
   input  wire logic [31:0]            ppa,
   input  wire logic                   mark,
   input  wire logic [CW-1:0]          count,
   input  wire logic                   left_lt,
   input  wire logic [EW-1:0]          left_entry,
   input  wire logic [EW-1:0]          right_entry,
   output logic                        lt,
   output logic [EW-1:0]               entry,
   output logic [EW:0]                 pick_entry
);

   // entry layout: {key, ppa, mark}
   logic [EW-1:0] entry_ff, entry_in;
   logic          lt_ff, lt_in;
   logic          pick_ff, pick_in;
   logic          occupied;
   logic          is_head;

   assign occupied = CW'(INDEX) < count;
   assign is_head  = INDEX == 0;

   always_comb begin
      lt_in   = lt_ff;
      pick_in = pick_ff;
      if (ctl.cmp_en) begin
         lt_in   = occupied && !ctl.pop && (entry_ff[EW-1:33] < key);
         pick_in = occupied && (ctl.pop ? is_head : (entry_ff[EW-1:33] == key));
      end
   end

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         sktab_pkg::OP_INSERT: begin
            if (!lt_ff) begin
               entry_in = left_lt ? {key, ppa, mark} : left_entry;
            end
         end
         sktab_pkg::OP_UPDATE: begin
            if (pick_ff) begin
               entry_in = {entry_ff[EW-1:33], ppa, mark};
            end
         end
         sktab_pkg::OP_REMOVE: begin
            if (!lt_ff) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      pick_ff  <= pick_in;
   end

   assign lt         = lt_ff;
   assign entry      = entry_ff;
   assign pick_entry = pick_ff ? {1'b1, entry_ff} : '0;

endmodule
`default_nettype wire

/* hdl/sktab_or_tree.sv */
`default_nettype none
module sktab_or_tree #(
   parameter int N = sktab_pkg::CAPACITY_DEF,
   parameter int W = 65,
   localparam int G  = sktab_pkg::GROUP,
   localparam int NG = (N + G - 1) / G
) (
   input  wire logic                 clock,
   input  wire logic [N-1:0][W-1:0]  leaf,
   output logic [W-1:0]              root
);

   // two registered levels: groups of G leaves, then all groups
   logic [NG-1:0][W-1:0] group_ff, group_in;
   logic [W-1:0]         root_ff, root_in;

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < G; j++) begin
            if (g * G + j < N) begin
               group_in[g] = group_in[g] | leaf[g * G + j];
            end
         end
      end
   end

   always_comb begin
      root_in = '0;
      for (int g = 0; g < NG; g++) begin
         root_in = root_in | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
      root_ff  <= root_in;
   end

   assign root = root_ff;

endmodule
`default_nettype wire

/* hdl/sorted_key_address_table.sv */
// Sorted key to page-address table.
// Input channel req_*: one beat is one command (insert, find, delete, pop
// smallest, clear) with key, address and valid mark. Result channel rsp_*:
// exactly one beat per command, carrying status, the entry that was found,
// removed or popped, the replaced address on update, the entry count and the
// lowest and highest key ever inserted.
// Entries live in a row of cells kept in key order; every cell compares its
// key against the command key in parallel, and inserts and removals move the
// tail of the row one cell right or left together in the apply step.
// A command accepted on req_* passes the compare, the two registered levels
// of the OR tree that reads the selected cell out and the apply step, which
// loads the result register. The block takes one command at a time:
// req_tready is low from the accept until the apply step is done. A new
// command is taken while the previous result still waits on rsp_*; if the
// receiver stalls, the apply step holds until the result register frees,
// and req_tready stays low meanwhile.
// Reset: the table is empty, the lowest key reads all ones and the highest
// zero, req_tready is low. Cell contents are not cleared; only cells below
// the count are used. Clear empties the table but keeps the key range.
`default_nettype none
module sorted_key_address_table #(
   parameter int CAPACITY  = sktab_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = sktab_pkg::KEY_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // cmd[2:0], key[33:3], ppa[65:34], valid_flag[66], zero pad
   input  wire logic [sktab_pkg::REQ_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // status[2:0], out_key[33:3], out_ppa[65:34], out_valid[66],
   // old_ppa[98:67], entry_count[107:99], low_key[139:108],
   // high_key[171:140], zero pad
   output logic [sktab_pkg::RSP_W-1:0]      rsp_tdata
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = KEY_WIDTH + 33;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RED1,
      S_RED2,
      S_APPLY
   } state_type;

   state_type             state_ff;
   sktab_pkg::cmd_type    cmd_ff;
   logic [KEY_WIDTH-1:0]  key_ff;
   logic [31:0]           ppa_ff;
   logic                  mark_ff;
   logic [CW-1:0]         count_ff;
   logic [31:0]           low_ff;
   logic [31:0]           high_ff;
   logic                  rsp_valid_ff;
   logic [sktab_pkg::RSP_W-1:0] rsp_data_ff;

   // request fields
   logic                  req_beat;
   sktab_pkg::cmd_type    req_cmd;
   logic [31:0]           req_key32;
   logic [KEY_WIDTH-1:0]  key_sel;

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign req_beat   = req_tvalid && req_tready;
   assign req_cmd    = sktab_pkg::cmd_type'(req_tdata[2:0]);
   assign req_key32  = {1'b0, req_tdata[33:3]};
   assign key_sel    = req_beat ? req_key32[KEY_WIDTH-1:0] : key_ff;

   // cell row
   sktab_pkg::cell_ctl_type       ctl;
   sktab_pkg::cell_op_type        op_c;
   logic [CAPACITY-1:0]           lt;
   logic [CAPACITY-1:0][EW-1:0]   entry;
   logic [CAPACITY-1:0][EW:0]     pick;
   logic                          can_load;

   assign can_load   = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_tready);
   assign ctl.cmp_en = req_beat;
   assign ctl.pop    = req_cmd == sktab_pkg::CMD_POP;
   assign ctl.op     = can_load ? op_c : sktab_pkg::OP_NONE;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic          left_lt;
      logic [EW-1:0] left_entry;
      logic [EW-1:0] right_entry;
      if (i == 0) begin : g_head
         assign left_lt    = 1'b1;
         assign left_entry = entry[i];
      end else begin : g_body
         assign left_lt    = lt[i-1];
         assign left_entry = entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = entry[i];
      end else begin : g_inner
         assign right_entry = entry[i+1];
      end
      sktab_cell #(
         .INDEX     (i),
         .KEY_WIDTH (KEY_WIDTH),
         .CW        (CW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .key         (key_sel),
         .ppa         (ppa_ff),
         .mark        (mark_ff),
         .count       (count_ff),
         .left_lt     (left_lt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .lt          (lt[i]),
         .entry       (entry[i]),
         .pick_entry  (pick[i])
      );
   end

   // readout of the picked cell through the two registered levels of the OR tree
   logic [EW:0] found;

   sktab_or_tree #(
      .N (CAPACITY),
      .W (EW + 1)
   ) u_tree (
      .clock (clock),
      .leaf  (pick),
      .root  (found)
   );

   logic                 hit;
   logic [31:0]          found_key32;
   logic [31:0]          found_ppa;
   logic                 found_mark;
   logic [31:0]          cmd_key32;

   assign hit         = found[EW];
   assign found_key32 = 32'(found[EW-1:33]);
   assign found_ppa   = found[32:1];
   assign found_mark  = found[0];
   assign cmd_key32   = 32'(key_ff);

   // result of the apply step
   sktab_pkg::status_type status_c;
   logic [31:0]           okey_c;
   logic [31:0]           oppa_c;
   logic                  oval_c;
   logic [31:0]           oldp_c;
   logic [CW-1:0]         count_c;
   logic [31:0]           low_c;
   logic [31:0]           high_c;
   logic [31:0]           count32;
   logic                  touch_range;

   always_comb begin
      status_c    = sktab_pkg::ST_MISS;
      okey_c      = '0;
      oppa_c      = '0;
      oval_c      = 1'b0;
      oldp_c      = '0;
      count_c     = count_ff;
      op_c        = sktab_pkg::OP_NONE;
      touch_range = 1'b0;
      case (cmd_ff)
         sktab_pkg::CMD_INSERT: begin
            if (hit) begin
               status_c    = sktab_pkg::ST_UPDATED;
               oldp_c      = found_ppa;
               op_c        = sktab_pkg::OP_UPDATE;
               touch_range = 1'b1;
            end else if (count_ff >= CW'(CAPACITY)) begin
               status_c = sktab_pkg::ST_FULL;
            end else begin
               status_c    = sktab_pkg::ST_NEW;
               op_c        = sktab_pkg::OP_INSERT;
               count_c     = count_ff + 1'b1;
               touch_range = 1'b1;
            end
         end
         sktab_pkg::CMD_FIND: begin
            if (hit) begin
               status_c = sktab_pkg::ST_HIT;
               okey_c   = found_key32;
               oppa_c   = found_ppa;
               oval_c   = found_mark;
            end
         end
         sktab_pkg::CMD_DELETE, sktab_pkg::CMD_POP: begin
            if (count_ff == '0) begin
               status_c = sktab_pkg::ST_EMPTY;
            end else if (hit) begin
               status_c = sktab_pkg::ST_HIT;
               okey_c   = found_key32;
               oppa_c   = found_ppa;
               oval_c   = found_mark;
               op_c     = sktab_pkg::OP_REMOVE;
               count_c  = count_ff - 1'b1;
            end
         end
         sktab_pkg::CMD_CLEAR: begin
            status_c = sktab_pkg::ST_HIT;
            count_c  = '0;
         end
         default: begin
            status_c = sktab_pkg::ST_MISS;
         end
      endcase
      low_c  = low_ff;
      high_c = high_ff;
      if (touch_range && (cmd_key32 < low_ff)) begin
         low_c = cmd_key32;
      end
      if (touch_range && (cmd_key32 > high_ff)) begin
         high_c = cmd_key32;
      end
      count32 = 32'(count_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         low_ff       <= '1;
         high_ff      <= '0;
      end else begin
         // result register: load on apply, else drain on handshake
         if (can_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff   <= req_cmd;
                  key_ff   <= req_key32[KEY_WIDTH-1:0];
                  ppa_ff   <= req_tdata[65:34];
                  mark_ff  <= req_tdata[66];
                  state_ff <= S_RED1;
               end
            end
            S_RED1: begin
               state_ff <= S_RED2;
            end
            S_RED2: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (can_load) begin
                  count_ff     <= count_c;
                  low_ff       <= low_c;
                  high_ff      <= high_c;
                  rsp_data_ff  <= {4'd0, high_c, low_c, count32[8:0], oldp_c,
                                   oval_c, oppa_c, okey_c[30:0], status_c};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

/* hdl/sktab_checker.sv */
`default_nettype none
module sktab_checker #(
   parameter int CAPACITY = sktab_pkg::CAPACITY_DEF
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [sktab_pkg::RSP_W-1:0] rsp_tdata
);

   logic [2:0]  st;
   logic [31:0] cnt;
   logic [31:0] lowk;
   logic [31:0] highk;

   assign st         = rsp_tdata[2:0];
   assign cnt        = {23'd0, rsp_tdata[107:99]};
   assign lowk       = rsp_tdata[139:108];
   assign highk      = rsp_tdata[171:140];

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // one command in flight: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken back to back");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt <= CAPACITY)
      else $error("entry count above capacity");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st == sktab_pkg::ST_FULL |-> cnt == CAPACITY)
      else $error("full reported below capacity");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (st == sktab_pkg::ST_NEW || st == sktab_pkg::ST_UPDATED)
      |-> lowk <= highk)
      else $error("key range inverted after insert");

endmodule

bind sorted_key_address_table sktab_checker #(
   .CAPACITY (CAPACITY)
) u_sktab_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

/* bench/sorted_key_address_table_tb.sv */
`default_nettype none
module sorted_key_address_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = sktab_pkg::CAPACITY_DEF;
   localparam int LIMIT_CYCLES = 400000;
   // largest key the tests use, one below the top of the 31-bit key field
   localparam logic [30:0] KEY_TOP = 31'h7FFF_FFFE;
   // top of the 3-bit command field; codes above CMD_CLEAR are unused
   localparam int CODE_TOP = (1 << $bits(sktab_pkg::cmd_type)) - 1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [sktab_pkg::REQ_W-1:0]   req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [sktab_pkg::RSP_W-1:0]   rsp_tdata;

   // one table row as the block keeps it
   typedef struct {
      logic [30:0] key;
      logic [31:0] addr;
      logic        mark;
   } row_type;

   // reply fields, MSB first, so the low 172 bits of rsp_tdata map straight in
   typedef struct packed {
      logic [31:0]           high;
      logic [31:0]           low;
      logic [8:0]            count;
      logic [31:0]           old_addr;
      logic                  mark;
      logic [31:0]           addr;
      logic [30:0]           key;
      sktab_pkg::status_type status;
   } reply_type;

   row_type     rows[$];              // predicted table contents, ascending key
   logic [31:0] seen_low  = '1;       // lowest key ever inserted
   logic [31:0] seen_high = '0;       // highest key ever inserted
   reply_type   replies_due[$];       // predicted replies not yet seen
   int          bad_count = 0;
   int          cycles = 0;
   bit          idle_on = 1'b1;       // random gaps on both channels

   sorted_key_address_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Table predictor: applies one command to the row list, returns the reply.
   // -------------------------------------------------------------------------
   function automatic reply_type apply_table_cmd(logic [2:0] code, logic [30:0] key,
                                                 logic [31:0] addr, logic mark);
      reply_type r;
      int        slot;
      bit        hit;
      row_type   e;
      r = '0;
      r.status = sktab_pkg::ST_MISS;
      // first row whose key is not below the command key
      slot = 0;
      while (slot < rows.size() && rows[slot].key < key)
         slot++;
      hit = (slot < rows.size()) && (rows[slot].key == key);
      e.key = key;
      e.addr = addr;
      e.mark = mark;
      case (code)
         sktab_pkg::CMD_INSERT: begin
            if (hit) begin
               r.old_addr = rows[slot].addr;
               rows[slot] = e;
               r.status = sktab_pkg::ST_UPDATED;
            end else if (rows.size() >= DEPTH) begin
               // rejected: table and seen range untouched
               r.status = sktab_pkg::ST_FULL;
            end else begin
               rows.insert(slot, e);
               r.status = sktab_pkg::ST_NEW;
            end
            if (r.status != sktab_pkg::ST_FULL) begin
               if ({1'b0, key} < seen_low)  seen_low  = {1'b0, key};
               if ({1'b0, key} > seen_high) seen_high = {1'b0, key};
            end
         end
         sktab_pkg::CMD_FIND: begin
            if (hit) begin
               {r.key, r.addr, r.mark} = {rows[slot].key, rows[slot].addr, rows[slot].mark};
               r.status = sktab_pkg::ST_HIT;
            end
         end
         sktab_pkg::CMD_DELETE: begin
            if (rows.size() == 0) begin
               r.status = sktab_pkg::ST_EMPTY;
            end else if (hit) begin
               {r.key, r.addr, r.mark} = {rows[slot].key, rows[slot].addr, rows[slot].mark};
               rows.delete(slot);
               r.status = sktab_pkg::ST_HIT;
            end
         end
         sktab_pkg::CMD_POP: begin
            if (rows.size() == 0) begin
               r.status = sktab_pkg::ST_EMPTY;
            end else begin
               {r.key, r.addr, r.mark} = {rows[0].key, rows[0].addr, rows[0].mark};
               rows.delete(0);
               r.status = sktab_pkg::ST_HIT;
            end
         end
         sktab_pkg::CMD_CLEAR: begin
            // seen range survives a clear
            rows.delete();
            r.status = sktab_pkg::ST_HIT;
         end
         default: ;  // unused code: no state change, miss
      endcase
      r.count = 9'(rows.size());
      r.low = seen_low;
      r.high = seen_high;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Request side: one beat per call. Entered and left at a falling edge.
   // -------------------------------------------------------------------------
   task automatic issue_cmd(logic [2:0] code, logic [30:0] key, logic [31:0] addr,
                            logic mark);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tdata <= {{(sktab_pkg::REQ_W - 67){1'b0}}, mark, addr, key, code};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      // beat taken at this edge: predict now so order matches the block
      replies_due.push_back(apply_table_cmd(code, key, addr, mark));
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Response side: random stall bursts on rsp_tready.
   // -------------------------------------------------------------------------
   always begin
      @(negedge clock);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      rsp_tready <= 1'b1;
   end

   function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         bad_count++;
      end
   endfunction

   // every reply beat is matched against the oldest prediction
   always @(posedge clock) begin : match_reply
      reply_type got;
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(reply_type)-1:0];
         if (replies_due.size() == 0) begin
            $display("%0t ns: unexpected reply beat, expected none, actual %h", $time, got);
            bad_count++;
         end else begin
            want = replies_due.pop_front();
            compare_field("status",      32'(want.status),   32'(got.status));
            compare_field("out_key",     32'(want.key),      32'(got.key));
            compare_field("out_ppa",     want.addr,          got.addr);
            compare_field("out_valid",   32'(want.mark),     32'(got.mark));
            compare_field("old_ppa",     want.old_addr,      got.old_addr);
            compare_field("entry_count", 32'(want.count),    32'(got.count));
            compare_field("low_key",     want.low,           got.low);
            compare_field("high_key",    want.high,          got.high);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // fresh table: seen range still at reset values
   task automatic test_empty_table();
      issue_cmd(sktab_pkg::CMD_FIND,   KEY_TOP, '1, 1'b1);
      issue_cmd(sktab_pkg::CMD_DELETE, 31'd0,   '0, 1'b0);
      issue_cmd(sktab_pkg::CMD_POP,    31'd5,   $urandom, 1'b1);
      issue_cmd(sktab_pkg::CMD_CLEAR,  31'd0,   '0, 1'b0);
      for (int c = sktab_pkg::CMD_CLEAR + 1; c <= CODE_TOP; c++)
         issue_cmd(3'(c), 31'($urandom_range(0, KEY_TOP)), $urandom, 1'($urandom));
   endtask

   // fill to capacity in scattered key order, then push against the limit
   task automatic test_full_table();
      int pick;
      // 97 is odd, so i*97 mod 256 visits every slot once; key 0 stays absent
      for (int i = 0; i < DEPTH; i++)
         issue_cmd(sktab_pkg::CMD_INSERT,
                   31'(1000 + ((i * 97) % 256) * 1000 + $urandom_range(0, 999)),
                   $urandom, 1'($urandom));
      // new keys rejected; seen range must not widen
      issue_cmd(sktab_pkg::CMD_INSERT, 31'd0,   $urandom, 1'b1);
      issue_cmd(sktab_pkg::CMD_INSERT, KEY_TOP, $urandom, 1'b0);
      // existing key still updates while full
      pick = $urandom_range(0, DEPTH - 1);
      issue_cmd(sktab_pkg::CMD_INSERT, rows[pick].key, $urandom, 1'($urandom));
      issue_cmd(sktab_pkg::CMD_FIND,   rows[pick].key, $urandom, 1'($urandom));
      // free one row at the tail, refill it, overfill again
      issue_cmd(sktab_pkg::CMD_DELETE, rows[DEPTH - 1].key, $urandom, 1'($urandom));
      issue_cmd(sktab_pkg::CMD_INSERT, 31'd500, $urandom, 1'($urandom));
      issue_cmd(sktab_pkg::CMD_INSERT, 31'd400, $urandom, 1'($urandom));
      repeat (4)
         issue_cmd(sktab_pkg::CMD_POP, 31'($urandom_range(0, KEY_TOP)), $urandom,
                   1'($urandom));
      issue_cmd(sktab_pkg::CMD_CLEAR, 31'd0, '0, 1'b0);
   endtask

   // directed walk over every command and the edge values of each field
   task automatic test_basic_ops();
      issue_cmd(sktab_pkg::CMD_INSERT, 31'd0,          32'h0000_0000, 1'b0);
      issue_cmd(sktab_pkg::CMD_INSERT, KEY_TOP,        32'hFFFF_FFFF, 1'b1);
      issue_cmd(sktab_pkg::CMD_INSERT, 31'h2AAA_AAAA,  32'h5555_5555, 1'b1);
      issue_cmd(sktab_pkg::CMD_INSERT, 31'h5555_5555,  32'hAAAA_AAAA, 1'b0);
      // update returns the replaced address
      issue_cmd(sktab_pkg::CMD_INSERT, 31'h2AAA_AAAA,  32'h1234_5678, 1'b0);
      issue_cmd(sktab_pkg::CMD_FIND,   KEY_TOP,        '0, 1'b0);
      issue_cmd(sktab_pkg::CMD_FIND,   31'd1,          '1, 1'b1);
      issue_cmd(sktab_pkg::CMD_DELETE, 31'd5,          '0, 1'b0);
      issue_cmd(sktab_pkg::CMD_DELETE, 31'h2AAA_AAAA,  '0, 1'b0);
      issue_cmd(sktab_pkg::CMD_POP,    31'd0,          '0, 1'b0);
      issue_cmd(sktab_pkg::CMD_FIND,   31'd0,          '0, 1'b0);
      issue_cmd(3'(CODE_TOP),          KEY_TOP,        '1, 1'b1);
      issue_cmd(sktab_pkg::CMD_CLEAR,  31'd0,          '0, 1'b0);
      // table empty again, seen range kept
      issue_cmd(sktab_pkg::CMD_FIND,   31'h5555_5555,  '0, 1'b0);
      issue_cmd(sktab_pkg::CMD_DELETE, 31'h5555_5555,  '0, 1'b0);
      issue_cmd(sktab_pkg::CMD_POP,    31'd0,          '0, 1'b0);
      issue_cmd(sktab_pkg::CMD_INSERT, 31'd7,          32'hDEAD_BEEF, 1'b1);
      issue_cmd(sktab_pkg::CMD_INSERT, 31'd3,          32'h0BAD_F00D, 1'b0);
      issue_cmd(sktab_pkg::CMD_POP,    31'd0,          '0, 1'b0);
   endtask

   // random traffic; keys mostly from a small pool so finds and deletes hit
   task automatic test_random_mix(int n_items);
      logic [30:0] pool [0:31];
      logic [30:0] k;
      int          r;
      int          done;
      for (int i = 0; i < 32; i++)
         pool[i] = (i < 2) ? 31'(i) :
                   (i < 4) ? KEY_TOP - 31'(i - 2) :
                   31'($urandom_range(0, KEY_TOP));
      done = 0;
      while (done < n_items) begin
         r = $urandom_range(0, 99);
         k = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 31)] :
                                           31'($urandom_range(0, KEY_TOP));
         if (r < 12) begin
            // full life of one key: add, look up, rewrite, remove, miss
            issue_cmd(sktab_pkg::CMD_INSERT, k, $urandom, 1'($urandom));
            issue_cmd(sktab_pkg::CMD_FIND,   k, $urandom, 1'($urandom));
            issue_cmd(sktab_pkg::CMD_INSERT, k, $urandom, 1'($urandom));
            issue_cmd(sktab_pkg::CMD_DELETE, k, $urandom, 1'($urandom));
            issue_cmd(sktab_pkg::CMD_FIND,   k, $urandom, 1'($urandom));
            done += 5;
         end else begin
            if (r < 45)
               issue_cmd(sktab_pkg::CMD_INSERT, k, $urandom, 1'($urandom));
            else if (r < 62)
               issue_cmd(sktab_pkg::CMD_FIND, k, $urandom, 1'($urandom));
            else if (r < 80)
               issue_cmd(sktab_pkg::CMD_DELETE, k, $urandom, 1'($urandom));
            else if (r < 92)
               issue_cmd(sktab_pkg::CMD_POP, k, $urandom, 1'($urandom));
            else if (r < 94)
               issue_cmd(sktab_pkg::CMD_CLEAR, k, $urandom, 1'($urandom));
            else if (r < 97)
               issue_cmd(3'($urandom_range(sktab_pkg::CMD_CLEAR + 1, CODE_TOP)), k,
                         $urandom, 1'($urandom));
            else
               issue_cmd(sktab_pkg::CMD_FIND, 31'($urandom_range(0, KEY_TOP)), $urandom,
                         1'($urandom));
            done++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_table();
      test_full_table();
      test_basic_ops();
      test_random_mix(500);
      // last stretch back to back, no gaps on either side
      idle_on = 1'b0;
      test_random_mix(200);

      // let every reply come home, then wait on to catch strays
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      if (bad_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire
